// ----- hw/rtl/siq_pkg.sv -----
// Shared types and codes of the sorted insert queue.
`timescale 1ns / 1ps

package siq_pkg;

  localparam int CMD_BITS        = 2;
  localparam int POS_BITS        = 5;
  localparam int STATUS_BITS     = 3;
  localparam int OUT_HANDLE_BITS = 16;
  localparam int COUNT_BITS      = 5;

  localparam logic [CMD_BITS-1:0] CMD_ORDERED = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_AT_POS  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_POP     = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE  = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [STATUS_BITS-1:0]     status;
    logic [OUT_HANDLE_BITS-1:0] popped_handle;
    logic [OUT_HANDLE_BITS-1:0] front_handle;
    logic [OUT_HANDLE_BITS-1:0] back_handle;
    logic [COUNT_BITS-1:0]      entry_count;
  } siq_result_t;

endpackage

// ----- hw/rtl/siq_if.sv -----
// Command and result channel interfaces of the sorted insert queue.
`timescale 1ns / 1ps

interface siq_in_if #(
  parameter int HANDLE_BITS = 16,
  parameter int KEY_BITS    = 16
) ();
  import siq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_BITS-1:0]    cmd;
  logic [HANDLE_BITS-1:0] item_handle;
  logic [KEY_BITS-1:0]    item_key;
  logic [POS_BITS-1:0]    position;

  modport source (output valid, cmd, item_handle, item_key, position, input ready);
  modport sink   (input valid, cmd, item_handle, item_key, position, output ready);
endinterface

interface siq_out_if ();
  import siq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_BITS-1:0]     status;
  logic [OUT_HANDLE_BITS-1:0] popped_handle;
  logic [OUT_HANDLE_BITS-1:0] front_handle;
  logic [OUT_HANDLE_BITS-1:0] back_handle;
  logic [COUNT_BITS-1:0]      entry_count;

  modport source (output valid, status, popped_handle, front_handle, back_handle,
                  entry_count, input ready);
  modport sink   (input valid, status, popped_handle, front_handle, back_handle,
                  entry_count, output ready);
endinterface

// ----- hw/rtl/siq_mem.sv -----
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps

module siq_mem #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/siq_seq.sv -----
// Sequencer that scans and shifts the entry store one slot at a time.
`timescale 1ns / 1ps

module siq_seq #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 16,
  parameter int KEY_BITS    = 16,
  parameter int IDX_W       = $clog2(CAPACITY),
  parameter int DATA_W      = HANDLE_BITS + KEY_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [siq_pkg::CMD_BITS-1:0] cmd_i,
  input  logic [HANDLE_BITS-1:0]       handle_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [siq_pkg::POS_BITS-1:0] pos_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output siq_pkg::siq_result_t         res_o,
  output logic                         mem_we_o,
  output logic [IDX_W-1:0]             mem_waddr_o,
  output logic [DATA_W-1:0]            mem_wdata_o,
  output logic [IDX_W-1:0]             mem_raddr_o,
  input  logic [DATA_W-1:0]            mem_rdata_i
);
  import siq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SW    = 4;

  localparam logic [SW-1:0] S_IDLE     = 4'd0;
  localparam logic [SW-1:0] S_SCAN_RD  = 4'd1;
  localparam logic [SW-1:0] S_SCAN_CMP = 4'd2;
  localparam logic [SW-1:0] S_INS_RD   = 4'd3;
  localparam logic [SW-1:0] S_INS_WR   = 4'd4;
  localparam logic [SW-1:0] S_POP_RD   = 4'd5;
  localparam logic [SW-1:0] S_POP_CAP  = 4'd6;
  localparam logic [SW-1:0] S_REM_RD   = 4'd7;
  localparam logic [SW-1:0] S_REM_WR   = 4'd8;
  localparam logic [SW-1:0] S_RPT_F    = 4'd9;
  localparam logic [SW-1:0] S_RPT_B    = 4'd10;
  localparam logic [SW-1:0] S_RPT_L    = 4'd11;
  localparam logic [SW-1:0] S_DONE     = 4'd12;

  logic [SW-1:0]              state_q, state_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]           at_q, at_d;
  logic [CMD_BITS-1:0]        cmd_q, cmd_d;
  logic [HANDLE_BITS-1:0]     handle_q, handle_d;
  logic [KEY_BITS-1:0]        key_q, key_d;
  logic [STATUS_BITS-1:0]     status_q, status_d;
  logic [OUT_HANDLE_BITS-1:0] popped_q, popped_d;
  logic [OUT_HANDLE_BITS-1:0] front_q, front_d;
  logic [OUT_HANDLE_BITS-1:0] back_q, back_d;

  logic [HANDLE_BITS-1:0] rd_handle;
  logic [KEY_BITS-1:0]    rd_key;
  logic                   hit;
  logic [CNT_W-1:0]       idx_m1, idx_p1, count_m1;
  logic                   is_full, is_empty, pos_bad;

  logic [POS_BITS+CNT_W-1:0]                pos_ext, count_ext;
  logic [HANDLE_BITS+OUT_HANDLE_BITS-1:0]   rd_handle_ext;
  logic [CNT_W+COUNT_BITS-1:0]              count_out_ext;

  assign rd_handle = mem_rdata_i[DATA_W-1:KEY_BITS];
  assign rd_key    = mem_rdata_i[KEY_BITS-1:0];

  // The one compare unit: key order for ordered insert, handle match for remove.
  assign hit = (cmd_q == CMD_ORDERED) ? (rd_key >= key_q) : (rd_handle == handle_q);

  assign idx_m1   = idx_q - CNT_W'(1);
  assign idx_p1   = idx_q + CNT_W'(1);
  assign count_m1 = count_q - CNT_W'(1);

  assign is_full   = (count_q >= CNT_W'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign pos_ext   = {{CNT_W{1'b0}}, pos_i};
  assign count_ext = {{POS_BITS{1'b0}}, count_q};
  assign pos_bad   = (pos_ext > count_ext);

  assign rd_handle_ext = {{OUT_HANDLE_BITS{1'b0}}, rd_handle};
  assign count_out_ext = {{COUNT_BITS{1'b0}}, count_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    at_d        = at_q;
    cmd_d       = cmd_q;
    handle_d    = handle_q;
    key_d       = key_q;
    status_d    = status_q;
    popped_d    = popped_q;
    front_d     = front_q;
    back_d      = back_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[IDX_W-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_q[IDX_W-1:0];
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = cmd_i;
          handle_d = handle_i;
          key_d    = key_i;
          status_d = ST_OK;
          popped_d = '0;
          idx_d    = '0;
          case (cmd_i)
            CMD_ORDERED: begin
              if (is_full) begin
                status_d = ST_FULL;
                state_d  = S_RPT_F;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            CMD_AT_POS: begin
              if (pos_bad) begin
                status_d = ST_BADPOS;
                state_d  = S_RPT_F;
              end else if (is_full) begin
                status_d = ST_FULL;
                state_d  = S_RPT_F;
              end else begin
                at_d    = pos_ext[CNT_W-1:0];
                idx_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            CMD_POP: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
                state_d  = S_RPT_F;
              end else begin
                state_d = S_POP_RD;
              end
            end
            default: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
                state_d  = S_RPT_F;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          if (cmd_q == CMD_ORDERED) begin
            at_d    = idx_q;
            state_d = S_INS_RD;
          end else begin
            status_d = ST_NOTFOUND;
            state_d  = S_RPT_F;
          end
        end else begin
          state_d = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (hit) begin
          if (cmd_q == CMD_ORDERED) begin
            at_d    = idx_q;
            idx_d   = count_q;
            state_d = S_INS_RD;
          end else begin
            state_d = S_REM_RD;
          end
        end else begin
          idx_d   = idx_p1;
          state_d = S_SCAN_RD;
        end
      end

      // Shift the tail down by one slot, from the end toward the insert point.
      S_INS_RD: begin
        mem_raddr_o = idx_m1[IDX_W-1:0];
        if (idx_q == at_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = at_q[IDX_W-1:0];
          mem_wdata_o = {handle_q, key_q};
          count_d     = count_q + CNT_W'(1);
          state_d     = S_RPT_F;
        end else begin
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[IDX_W-1:0];
        mem_wdata_o = mem_rdata_i;
        idx_d       = idx_m1;
        state_d     = S_INS_RD;
      end

      S_POP_RD: begin
        mem_raddr_o = '0;
        state_d     = S_POP_CAP;
      end

      S_POP_CAP: begin
        popped_d = rd_handle_ext[OUT_HANDLE_BITS-1:0];
        idx_d    = '0;
        state_d  = S_REM_RD;
      end

      // Close the gap by pulling later entries up one slot.
      S_REM_RD: begin
        mem_raddr_o = idx_p1[IDX_W-1:0];
        if (idx_p1 == count_q) begin
          count_d = count_m1;
          state_d = S_RPT_F;
        end else begin
          state_d = S_REM_WR;
        end
      end

      S_REM_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[IDX_W-1:0];
        mem_wdata_o = mem_rdata_i;
        idx_d       = idx_p1;
        state_d     = S_REM_RD;
      end

      S_RPT_F: begin
        mem_raddr_o = '0;
        if (is_empty) begin
          front_d = '0;
          back_d  = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_RPT_B;
        end
      end

      S_RPT_B: begin
        front_d     = rd_handle_ext[OUT_HANDLE_BITS-1:0];
        mem_raddr_o = count_m1[IDX_W-1:0];
        state_d     = S_RPT_L;
      end

      S_RPT_L: begin
        back_d  = rd_handle_ext[OUT_HANDLE_BITS-1:0];
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    at_q     <= at_d;
    cmd_q    <= cmd_d;
    handle_q <= handle_d;
    key_q    <= key_d;
    status_q <= status_d;
    popped_q <= popped_d;
    front_q  <= front_d;
    back_q   <= back_d;
  end

  assign res_o.status        = status_q;
  assign res_o.popped_handle = popped_q;
  assign res_o.front_handle  = front_q;
  assign res_o.back_handle   = back_q;
  assign res_o.entry_count   = count_out_ext[COUNT_BITS-1:0];

endmodule

// ----- hw/rtl/sorted_insert_queue.sv -----
// Top level of the sorted insert queue: sequencer, entry store and result register.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// cmd_i     in         cmd, item_handle, item_key, position
// res_o     out        status, popped_handle, front_handle, back_handle, entry_count
//
// Each command beat is handled by a sequencer that owns the single port pair of the
// entry store and works through the beat slot by slot. An ordered insert or a remove
// scans with a read and a compare step per entry passed over; each slot moved by an
// insert or a removal takes a read and a write step; reporting reads head and tail in
// S_RPT_F, S_RPT_B and S_RPT_L, and accept and handoff use S_IDLE and S_DONE. Entries
// passed over and entries moved never add up to more than the count. Reset clears the
// entry count and the sequencer; the store contents are never cleared, since only
// slots below the count are used. cmd_i is ready only while the sequencer is idle. A
// finished result sits in an output register, so the next command is taken while res_o
// is stalled; the sequencer waits only if a second result is ready first.

module sorted_insert_queue #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 16,
  parameter int KEY_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  siq_in_if.sink    cmd_i,
  siq_out_if.source res_o
);
  import siq_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int DATA_W = HANDLE_BITS + KEY_BITS;

  logic              seq_res_valid;
  logic              seq_res_ready;
  siq_result_t       seq_res;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic        out_valid_q, out_valid_d;
  siq_result_t out_q;

  siq_seq #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS),
    .KEY_BITS    (KEY_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .cmd_i       (cmd_i.cmd),
    .handle_i    (cmd_i.item_handle),
    .key_i       (cmd_i.item_key),
    .pos_i       (cmd_i.position),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .res_o       (seq_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  siq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result when it is empty or being drained.
  assign seq_res_ready = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_res_valid && seq_res_ready) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      out_q <= seq_res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_q.status;
  assign res_o.popped_handle = out_q.popped_handle;
  assign res_o.front_handle  = out_q.front_handle;
  assign res_o.back_handle   = out_q.back_handle;
  assign res_o.entry_count   = out_q.entry_count;

endmodule

// ----- tb/sorted_insert_queue_tb.sv -----
// Self-checking testbench of the sorted insert queue: stimulus, mirror list and result checks.
`timescale 1ns / 1ps

// The bench drives command beats into cmd_i and checks every beat on res_o against
// a mirror of the entry list. The mirror is updated when a command is accepted. Each
// command yields exactly one result, so the expected results form a simple FIFO.
//
// Run outline:
//   - a directed opening covers the empty, bad position, full and not found cases,
//     equal keys, head and end inserts and a duplicate handle;
//   - four random phases with different idle mixes on both sides;
//   - one long output hold-off while commands keep coming, so that the block backs up;
//   - a drain between phases, during which no command is offered.
module sorted_insert_queue_tb;
  import siq_pkg::*;

  localparam int SLOTS       = 16;
  localparam int HBITS       = 16;
  localparam int KBITS       = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 300;

  // Mirror of the entry list. It predicts the result of every accepted command
  // and keeps those predictions until the matching result beat shows up.
  class queue_mirror;
    logic [HBITS-1:0] handles[SLOTS];
    logic [KBITS-1:0] keys[SLOTS];
    int               count;
    siq_result_t      expected_results[$];
    int               errors;
    int               checked;
    int               status_seen[5];

    function new();
      count   = 0;
      errors  = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void place(int at, logic [HBITS-1:0] h, logic [KBITS-1:0] k);
      for (int i = count; i > at; i--) begin
        handles[i] = handles[i-1];
        keys[i]    = keys[i-1];
      end
      handles[at] = h;
      keys[at]    = k;
      count++;
    endfunction

    function void drop(int at);
      for (int i = at; i + 1 < count; i++) begin
        handles[i] = handles[i+1];
        keys[i]    = keys[i+1];
      end
      count--;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_command(logic [CMD_BITS-1:0] op, logic [HBITS-1:0] h,
                               logic [KBITS-1:0] k, logic [POS_BITS-1:0] pos);
      int          i;
      siq_result_t r;
      r        = '0;
      r.status = ST_OK;
      i        = 0;
      case (op)
        CMD_ORDERED: begin
          if (count >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            // Stop at the first key that is not smaller, so the new entry goes ahead of equal keys.
            while (i < count && keys[i] < k) i++;
            place(i, h, k);
          end
        end
        CMD_AT_POS: begin
          // The position check comes before the full check.
          if (int'(pos) > count) r.status = ST_BADPOS;
          else if (count >= SLOTS) r.status = ST_FULL;
          else place(int'(pos), h, k);
        end
        CMD_POP: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped_handle = handles[0];
            drop(0);
          end
        end
        default: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            while (i < count && handles[i] != h) i++;
            if (i == count) r.status = ST_NOTFOUND;
            else drop(i);
          end
        end
      endcase
      if (count > 0) begin
        r.front_handle = handles[0];
        r.back_handle  = handles[count-1];
      end
      r.entry_count = COUNT_BITS'(count);
      status_seen[r.status]++;
      expected_results.push_back(r);
    endfunction

    function void check_result(siq_result_t got);
      siq_result_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("Unexpected result beat: status %0d count %0d",
                       got.status, got.entry_count));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.status !== want.status || got.popped_handle !== want.popped_handle ||
          got.front_handle !== want.front_handle || got.back_handle !== want.back_handle ||
          got.entry_count !== want.entry_count) begin
        flag($sformatf({"Result %0d mismatch (expected/actual): status %0d/%0d ",
                        "popped %h/%h front %h/%h back %h/%h count %0d/%0d"},
                       checked, want.status, got.status, want.popped_handle,
                       got.popped_handle, want.front_handle, got.front_handle,
                       want.back_handle, got.back_handle, want.entry_count,
                       got.entry_count));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic sink_held;

  // Idle mix of both sides, in percent of cycles, and the output hold-off request.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int sent           = 0;

  queue_mirror mirror;

  siq_in_if #(.HANDLE_BITS(HBITS), .KEY_BITS(KBITS)) cmd_if ();
  siq_out_if res_if ();

  sorted_insert_queue #(
    .CAPACITY   (SLOTS),
    .HANDLE_BITS(HBITS),
    .KEY_BITS   (KBITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Keys favor a tiny range so that equal keys are common, plus both extremes.
  function automatic logic [KBITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KBITS'($urandom_range(0, 7));
    else if (r < 45) return '0;
    else if (r < 50) return '1;
    return KBITS'($urandom);
  endfunction

  // A small handle pool makes duplicate handles in the list a regular event.
  function automatic logic [HBITS-1:0] pick_handle();
    if ($urandom_range(0, 99) < 40) return HBITS'($urandom_range(0, 7));
    return HBITS'($urandom);
  endfunction

  // Mostly a legal position, now and then one past the end or further.
  function automatic logic [POS_BITS-1:0] pick_position();
    if ($urandom_range(0, 99) < 85) return POS_BITS'($urandom_range(0, mirror.count));
    return POS_BITS'($urandom_range(mirror.count + 1, 31));
  endfunction

  // Offer one command beat and return at the edge where it is taken. The valid line
  // stays high after acceptance, so back-to-back beats need no extra assignment.
  task automatic issue_command(input logic [CMD_BITS-1:0] op, input logic [HBITS-1:0] h,
                               input logic [KBITS-1:0] k, input logic [POS_BITS-1:0] p);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= op;
    cmd_if.item_handle <= h;
    cmd_if.item_key    <= k;
    cmd_if.position    <= p;
    do @(posedge clk); while (!cmd_if.ready);
    mirror.note_command(op, h, k, p);
    sent++;
  endtask

  // Stop offering commands until every predicted result has been seen.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (mirror.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    issue_command(CMD_POP,     16'h0000, 16'h0000, 5'd0);   // pop on an empty list
    issue_command(CMD_REMOVE,  16'h1234, 16'h0000, 5'd0);   // remove on an empty list
    issue_command(CMD_AT_POS,  16'h0101, 16'h0101, 5'd1);   // position past the end
    issue_command(CMD_AT_POS,  16'h0202, 16'h0202, 5'd31);  // largest position code
    issue_command(CMD_AT_POS,  16'hFFFF, 16'hFFFF, 5'd0);   // head insert, top values
    issue_command(CMD_ORDERED, 16'h0001, 16'h8000, 5'd0);
    issue_command(CMD_ORDERED, 16'h0002, 16'h8000, 5'd0);   // goes ahead of its equal
    issue_command(CMD_ORDERED, 16'h0000, 16'h0000, 5'd0);   // smallest key to the head
    issue_command(CMD_ORDERED, 16'hAAAA, 16'hFFFF, 5'd0);   // equal to the tail key
    issue_command(CMD_AT_POS,  16'h5555, 16'h0000, 5'd5);   // insert at the end
    issue_command(CMD_AT_POS,  16'h0001, 16'h1234, 5'd2);   // duplicate handle mid-list
    issue_command(CMD_AT_POS,  16'h7777, 16'h0000, 5'd8);   // one past the end
    issue_command(CMD_REMOVE,  16'h0001, 16'h0000, 5'd0);   // only the first match goes
    issue_command(CMD_REMOVE,  16'hBEEF, 16'h0000, 5'd0);   // no match
    issue_command(CMD_POP,     16'h0000, 16'h0000, 5'd0);
    issue_command(CMD_REMOVE,  16'h5555, 16'h0000, 5'd0);   // remove the tail
    while (mirror.count < SLOTS) issue_command(CMD_ORDERED, pick_handle(), pick_key(), 5'd0);
    issue_command(CMD_ORDERED, 16'h3333, 16'h0000, 5'd0);   // full
    issue_command(CMD_AT_POS,  16'h3333, 16'h0000, 5'd16);  // full, position is legal
    issue_command(CMD_AT_POS,  16'h3333, 16'h0000, 5'd17);  // bad position wins over full
  endtask

  // Random commands in bursts: fill bursts push the list to full, drain bursts empty
  // it with pops and removes of stored handles, mixed bursts wander, and noise bursts
  // send fully random fields.
  task automatic run_random(input int n);
    int                  burst_kind;
    int                  burst_left;
    int                  roll;
    logic [CMD_BITS-1:0] op;
    logic [HBITS-1:0]    h;
    logic [KBITS-1:0]    k;
    logic [POS_BITS-1:0] p;
    burst_kind = 0;
    burst_left = 0;
    for (int j = 0; j < n; j++) begin
      if (burst_left == 0) begin
        roll       = $urandom_range(0, 99);
        burst_kind = (roll < 35) ? 0 : (roll < 65) ? 1 : (roll < 90) ? 2 : 3;
        burst_left = $urandom_range(4, 30);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      h    = pick_handle();
      k    = pick_key();
      p    = pick_position();
      case (burst_kind)
        0: op = (roll < 70) ? CMD_ORDERED : CMD_AT_POS;
        1: begin
          op = (roll < 50) ? CMD_POP : CMD_REMOVE;
          if (roll >= 50 && roll < 95 && mirror.count > 0)
            h = mirror.handles[$urandom_range(0, mirror.count - 1)];
        end
        2: begin
          op = CMD_BITS'($urandom_range(0, 3));
          if (op == CMD_REMOVE && roll < 70 && mirror.count > 0)
            h = mirror.handles[$urandom_range(0, mirror.count - 1)];
        end
        default: begin
          op = CMD_BITS'($urandom);
          h  = HBITS'($urandom);
          k  = KBITS'($urandom);
          p  = POS_BITS'($urandom);
        end
      endcase
      issue_command(op, h, k, p);
    end
  endtask

  // Result side: check each beat that moves, then choose ready for the next cycle.
  initial begin
    siq_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && res_if.valid && res_if.ready) begin
        got.status        = res_if.status;
        got.popped_handle = res_if.popped_handle;
        got.front_handle  = res_if.front_handle;
        got.back_handle   = res_if.back_handle;
        got.entry_count   = res_if.entry_count;
        mirror.check_result(got);
      end
      res_if.ready <= !sink_held && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long output hold-off, timed here so that the command side keeps pushing meanwhile.
  initial begin
    int held;
    sink_held = 1'b0;
    forever begin
      wait (hold_request > 0);
      held         = hold_request;
      hold_request = 0;
      sink_held <= 1'b1;
      repeat (held) @(posedge clk);
      sink_held <= 1'b0;
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (cmd_if.valid && cmd_if.ready) ||
          (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    mirror             = new();
    rst_n              = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.cmd         = CMD_ORDERED;
    cmd_if.item_handle = '0;
    cmd_if.item_key    = '0;
    cmd_if.position    = '0;
    res_if.ready       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      run_random(PHASE_ITEMS);
      if (ph == 0) begin
        // Hold the output while commands keep coming, so the block backs up.
        hold_request = HOLD_CYCLES;
        run_random(40);
      end
      wait_drained();
    end

    // Leave room for any stray result beat after the last expected one.
    repeat (100) @(posedge clk);
    if (mirror.expected_results.size() != 0)
      mirror.flag($sformatf("%0d results never arrived", mirror.expected_results.size()));

    $display("Run: %0d commands, %0d results checked over four idle mixes and one long hold-off.",
             sent, mirror.checked);
    $display("Status mix: ok %0d, bad position %0d, full %0d, empty %0d, not found %0d; %0d errors.",
             mirror.status_seen[ST_OK], mirror.status_seen[ST_BADPOS],
             mirror.status_seen[ST_FULL], mirror.status_seen[ST_EMPTY],
             mirror.status_seen[ST_NOTFOUND], mirror.errors);
    if (mirror.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
